>>> hdl/tksti_pkg.sv
// Shared constants and the request carry type for the top-k score table.
`default_nettype none

package tksti_pkg;

  // Table geometry.
  localparam int ENTRIES    = 10;
  localparam int GAMES      = 5;

  // Field widths fixed by the interface.
  localparam int GAME_IN_W  = 3;
  localparam int SCORE_W    = 20;
  localparam int INIT_W     = 24;
  localparam int RANK_OUT_W = 4;

  // Only games reachable through the 3-bit game index get storage.
  localparam int TABLES     = (GAMES > (2 ** GAME_IN_W)) ? (2 ** GAME_IN_W) : GAMES;
  localparam int GAME_W     = (TABLES > 1) ? $clog2(TABLES) : 1;
  localparam int RANK_W     = $clog2(ENTRIES);

  // One request (or the entry it displaced) moving down the row of cells.
  typedef struct packed {
    logic                vld;     // Carry slot is occupied.
    logic                live;    // Game is in range, so cells may update.
    logic                placed;  // The new entry has already landed.
    logic [GAME_W-1:0]   game;
    logic [RANK_W-1:0]   rank;    // Landing rank, counted while still moving.
    logic [SCORE_W-1:0]  score;
    logic [INIT_W-1:0]   inits;
  } tksti_carry_t;

endpackage

`default_nettype wire

>>> hdl/top_k_score_table_insert.sv
// Top level: per-game top-k score tables updated by a row of rank cells.
// One request at a time: a new request is accepted only after the previous
// one has walked down the row of ENTRIES cells, one rank per cycle, and its
// result is no longer parked in the holding slot.
// Reset: asynchronous, active low; all scores and initials clear to zero at
// once, and the block can accept a request as soon as reset is released.
`default_nettype none

module top_k_score_table_insert
  import tksti_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [GAME_IN_W-1:0]  game_index_i,
  input  wire logic [SCORE_W-1:0]    new_score_i,
  input  wire logic [7:0]            first_initial_i,
  input  wire logic [7:0]            second_initial_i,
  input  wire logic [7:0]            third_initial_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       taken_o,
  output logic [RANK_OUT_W-1:0]      rank_o
);

  tksti_carry_t              chain [ENTRIES+1];
  tksti_carry_t              launch_d;
  tksti_carry_t              launch_q;
  tksti_carry_t              exit_c;
  logic                      accept;
  logic                      busy_d, busy_q;
  logic                      hold_vld_d, hold_vld_q;
  logic                      hold_taken_d, hold_taken_q;
  logic [RANK_OUT_W-1:0]     hold_rank_d, hold_rank_q;
  logic                      out_vld_d, out_vld_q;
  logic                      out_taken_d, out_taken_q;
  logic [RANK_OUT_W-1:0]     out_rank_d, out_rank_q;
  logic                      exit_taken;
  logic [RANK_OUT_W-1:0]     exit_rank;
  logic                      out_free;

  // One request in flight at a time; a parked result also blocks intake.
  assign in_stall_o = busy_q || hold_vld_q;
  assign accept     = in_valid_i && !in_stall_o;

  // Form the request that enters the top rank.
  always_comb begin
    launch_d        = '0;
    launch_d.vld    = accept;
    launch_d.live   = (32'(game_index_i) < GAMES);
    launch_d.placed = 1'b0;
    launch_d.game   = game_index_i[GAME_W-1:0];
    launch_d.rank   = '0;
    launch_d.score  = new_score_i;
    launch_d.inits  = {third_initial_i, second_initial_i, first_initial_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_q <= '0;
    end else begin
      launch_q <= launch_d;
    end
  end

  // Row of rank cells, rank 0 at the top.
  assign chain[0] = launch_q;

  for (genvar r = 0; r < ENTRIES; r++) begin : g_cell
    tksti_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .carry_i (chain[r]),
      .carry_o (chain[r+1])
    );
  end

  assign exit_c     = chain[ENTRIES];
  assign exit_taken = exit_c.placed;
  assign exit_rank  = exit_c.placed ? RANK_OUT_W'(exit_c.rank) : '0;

  // Busy from acceptance until the request leaves the bottom rank.
  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (exit_c.vld) begin
      busy_d = 1'b0;
    end
  end

  // Output register with a one-deep holding slot behind it.
  assign out_free = !out_vld_q || !out_stall_i;

  always_comb begin
    out_vld_d    = out_vld_q;
    out_taken_d  = out_taken_q;
    out_rank_d   = out_rank_q;
    hold_vld_d   = hold_vld_q;
    hold_taken_d = hold_taken_q;
    hold_rank_d  = hold_rank_q;
    if (out_free) begin
      if (hold_vld_q) begin
        out_vld_d   = 1'b1;
        out_taken_d = hold_taken_q;
        out_rank_d  = hold_rank_q;
        hold_vld_d  = 1'b0;
      end else if (exit_c.vld) begin
        out_vld_d   = 1'b1;
        out_taken_d = exit_taken;
        out_rank_d  = exit_rank;
      end else begin
        out_vld_d = 1'b0;
      end
    end else if (exit_c.vld) begin
      hold_vld_d   = 1'b1;
      hold_taken_d = exit_taken;
      hold_rank_d  = exit_rank;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      busy_q     <= busy_d;
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_taken_q <= hold_taken_d;
    hold_rank_q  <= hold_rank_d;
    out_taken_q  <= out_taken_d;
    out_rank_q   <= out_rank_d;
  end

  assign out_valid_o = out_vld_q;
  assign taken_o     = out_taken_q;
  assign rank_o      = out_rank_q;

  // An accepted request keeps the block busy in the next cycle.
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q)
    else $error("accepted request did not mark the block busy");

  // A request only leaves the row while the block is busy.
  a_exit_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    exit_c.vld |-> busy_q)
    else $error("request left the row while idle");

  // A parked result never coexists with a request in flight.
  a_hold_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(hold_vld_q && busy_q))
    else $error("parked result while a request is in flight");

  // A refused entry always reports rank zero.
  a_refused_rank : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !taken_o |-> rank_o == '0)
    else $error("refused entry has a nonzero rank");

endmodule

`default_nettype wire

>>> hdl/tksti_cell.sv
// One rank of every game's table and the carry register to the next rank.
`default_nettype none

module tksti_cell
  import tksti_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire tksti_carry_t carry_i,
  output tksti_carry_t      carry_o
);

  logic [SCORE_W-1:0] score_q [TABLES];
  logic [INIT_W-1:0]  inits_q [TABLES];
  logic [SCORE_W-1:0] sel_score;
  logic [INIT_W-1:0]  sel_inits;
  logic               swap;
  tksti_carry_t       carry_d;
  tksti_carry_t       carry_q;

  // Look up this rank's entry for the requested game.
  assign sel_score = score_q[carry_i.game];
  assign sel_inits = inits_q[carry_i.game];

  // A carried entry takes this rank when it beats the stored score strictly,
  // and after the new entry has landed every lower rank simply shifts down.
  assign swap = carry_i.vld && carry_i.live &&
                (carry_i.placed || (carry_i.score > sel_score));

  // Build the carry for the next rank.
  always_comb begin
    carry_d = carry_i;
    if (swap) begin
      carry_d.score  = sel_score;
      carry_d.inits  = sel_inits;
      carry_d.placed = 1'b1;
    end else if (!carry_i.placed) begin
      carry_d.rank = RANK_W'(carry_i.rank + 1'b1);
    end
  end

  // Carry register toward the next rank.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '0;
    end else begin
      carry_q <= carry_d;
    end
  end

  // Stored entries, cleared to zero at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < TABLES; g++) begin
        score_q[g] <= '0;
        inits_q[g] <= '0;
      end
    end else if (swap) begin
      score_q[carry_i.game] <= carry_i.score;
      inits_q[carry_i.game] <= carry_i.inits;
    end
  end

  assign carry_o = carry_q;

  // A request is registered in this cell and handed on to the next rank.
  a_carry_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    carry_i.vld |=> carry_o.vld)
    else $error("carry lost in a cell");

  // Once the new entry has landed, the request stays marked as placed.
  a_placed_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    carry_i.vld && carry_i.placed |=> carry_o.placed)
    else $error("placed flag dropped");

  // A request for a game without a table never lands.
  a_dead_unplaced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    carry_i.vld && !carry_i.live |=> !carry_o.placed)
    else $error("out of range game was placed");

endmodule

`default_nettype wire
